### src/ips_pkg.sv
// Shared types and constants for the incremental PID step unit.
// No dependencies; every other file imports this package.
package ips_pkg;

  localparam int CFG_W              = 16;
  localparam int ERR_STATE_W        = 18;
  localparam int ERR_OUT_W          = 17;
  localparam int INC_W              = 32;
  localparam int APB_DATA_W         = 32;
  localparam int CFG_ADDR_W         = 4;
  localparam int DEF_GAIN_FRAC_BITS = 8;
  localparam int DEF_DATA_WIDTH     = 16;

  localparam logic [CFG_W-1:0] TS_RESET = CFG_W'(1);

  localparam logic signed [INC_W-1:0] INC_MAX = {1'b0, {(INC_W-1){1'b1}}};
  localparam logic signed [INC_W-1:0] INC_MIN = {1'b1, {(INC_W-1){1'b0}}};

  typedef enum logic [1:0] {
    REG_KP = 2'd0,
    REG_TI = 2'd1,
    REG_TD = 2'd2,
    REG_TS = 2'd3
  } ips_reg_t;

  typedef struct packed {
    logic [CFG_W-1:0] kp;
    logic [CFG_W-1:0] ti;
    logic [CFG_W-1:0] td;
    logic [CFG_W-1:0] ts;
  } ips_cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL,
    ST_DIV_I,
    ST_WAIT_I,
    ST_DIV_D,
    ST_WAIT_D,
    ST_SUM,
    ST_FIN
  } ips_state_t;

  typedef struct packed {
    logic load;
    logic diff;
    logic mul;
    logic div_i_start;
    logic div_d_start;
    logic i_take;
    logic i_clear;
    logic d_take;
    logic d_clear;
    logic sum;
    logic fin;
  } ips_cmd_t;

  typedef struct packed {
    logic i_off;
    logic d_off;
    logic div_done;
    logic out_busy;
  } ips_sts_t;

endpackage

### src/ips_if.sv
// Word channels of the incremental PID step unit: sample in, increment out.
// Depends on ips_pkg.
interface ips_in_if #(
  parameter int DATA_WIDTH = ips_pkg::DEF_DATA_WIDTH
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] setpoint;
  logic signed [DATA_WIDTH-1:0] measurement;

  modport source (output valid, output setpoint, output measurement, input ready);
  modport sink   (input valid, input setpoint, input measurement, output ready);
endinterface

interface ips_out_if;
  import ips_pkg::*;
  logic                        valid;
  logic                        ready;
  logic signed [INC_W-1:0]     increment;
  logic signed [ERR_OUT_W-1:0] error_now;

  modport source (output valid, output increment, output error_now, input ready);
  modport sink   (input valid, input increment, input error_now, output ready);
endinterface

### src/incremental_pid_step_unit.sv
// Top level of the incremental (velocity form) PID step unit.
// Depends on ips_pkg, ips_if, ips_regs, ips_div, ips_dp and ips_ctrl.
//
//   channel  | direction | word contents
//   ---------+-----------+--------------------------------------
//   in_ch    | sink      | setpoint, measurement
//   out_ch   | source    | increment, error_now
//   apb      | slave     | prop_gain, integral_time, derivative_time, sample_period
//
// One word at a time: per word the shared divider (two quotient bits per cycle over
// a 54-bit numerator at the default widths) runs twice, and each disabled term skips
// its divide. Synchronous active-low reset clears the sequencer, error history and
// registers. A finished increment waits in the output register while the next word
// is taken; a stalled output holds the sequencer in its last step.
module incremental_pid_step_unit #(
  parameter int GAIN_FRAC_BITS = ips_pkg::DEF_GAIN_FRAC_BITS,
  parameter int DATA_WIDTH     = ips_pkg::DEF_DATA_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  ips_in_if.sink                         in_ch,
  ips_out_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ips_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [ips_pkg::APB_DATA_W-1:0] pwdata,
  output logic [ips_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import ips_pkg::*;

  ips_cfg_t cfg;
  ips_cmd_t cmd;
  ips_sts_t sts;
  logic     in_ready;

  ips_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ips_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ips_dp #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
    .DATA_WIDTH     (DATA_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg         (cfg),
    .setpoint    (in_ch.setpoint),
    .measurement (in_ch.measurement),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .increment   (out_ch.increment),
    .error_now   (out_ch.error_now)
  );

  assign in_ch.ready = in_ready;

endmodule

### src/ips_regs.sv
// APB-style configuration registers: gain, integral, derivative, sample period.
// Depends on ips_pkg.
module ips_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ips_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [ips_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [ips_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  output ips_pkg::ips_cfg_t                 cfg
);
  import ips_pkg::*;

  ips_cfg_t         cfg_r;
  ips_cfg_t         cfg_nxt;
  ips_reg_t         sel;
  logic             wr_en;
  logic [CFG_W-1:0] rd_val;

  assign sel    = ips_reg_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (sel)
        REG_KP:  cfg_nxt.kp = pwdata[CFG_W-1:0];
        REG_TI:  cfg_nxt.ti = pwdata[CFG_W-1:0];
        REG_TD:  cfg_nxt.td = pwdata[CFG_W-1:0];
        REG_TS:  cfg_nxt.ts = pwdata[CFG_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_KP:  rd_val = cfg_r.kp;
      REG_TI:  rd_val = cfg_r.ti;
      REG_TD:  rd_val = cfg_r.td;
      REG_TS:  rd_val = cfg_r.ts;
      default: rd_val = '0;
    endcase
  end

  assign prdata = APB_DATA_W'(rd_val);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp <= '0;
      cfg_r.ti <= '0;
      cfg_r.td <= '0;
      cfg_r.ts <= TS_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### src/ips_div.sv
// Signed-by-unsigned divider, two quotient bits per cycle, truncating toward zero.
// Depends on ips_pkg only for house conventions; used by ips_dp.
module ips_div #(
  parameter int NUM_W = 54,
  parameter int DEN_W = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic [DEN_W-1:0]        den,
  output logic                    done,
  output logic signed [NUM_W-1:0] quot
);
  import ips_pkg::*;

  localparam int STEPS = 2;
  localparam int DIVW  = NUM_W + (NUM_W % STEPS);
  localparam int ITERS = DIVW / STEPS;
  localparam int CNT_W = (ITERS > 1) ? $clog2(ITERS) : 1;

  logic             busy_r;
  logic             done_r;
  logic             neg_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [DIVW-1:0]  quo_r;
  logic [DEN_W-1:0] rem_nxt;
  logic [DIVW-1:0]  quo_nxt;
  logic [NUM_W-1:0] num_u;
  logic [NUM_W-1:0] num_mag;
  logic [NUM_W-1:0] qmag;

  assign num_u   = num;
  assign num_mag = num[NUM_W-1] ? (~num_u + 1'b1) : num_u;

  always_comb begin
    logic [DEN_W:0] sh;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    for (int k = 0; k < STEPS; k++) begin
      sh      = {rem_nxt, quo_nxt[DIVW-1]};
      quo_nxt = {quo_nxt[DIVW-2:0], 1'b0};
      if (sh >= {1'b0, den_r}) begin
        sh         = sh - {1'b0, den_r};
        quo_nxt[0] = 1'b1;
      end
      rem_nxt = sh[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ITERS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      neg_r <= num[NUM_W-1];
      rem_r <= '0;
      quo_r <= DIVW'(num_mag);
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign qmag = quo_r[NUM_W-1:0];
  assign quot = neg_r ? $signed(~qmag + 1'b1) : $signed(qmag);
  assign done = done_r;

endmodule

### src/ips_dp.sv
// Datapath: error history, gain products, divider, sum, floor shift, saturation.
// Depends on ips_pkg and ips_div; driven by ips_ctrl commands.
module ips_dp #(
  parameter int GAIN_FRAC_BITS = ips_pkg::DEF_GAIN_FRAC_BITS,
  parameter int DATA_WIDTH     = ips_pkg::DEF_DATA_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  ips_pkg::ips_cmd_t                    cmd,
  output ips_pkg::ips_sts_t                    sts,
  input  ips_pkg::ips_cfg_t                    cfg,
  input  logic signed [DATA_WIDTH-1:0]         setpoint,
  input  logic signed [DATA_WIDTH-1:0]         measurement,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic signed [ips_pkg::INC_W-1:0]     increment,
  output logic signed [ips_pkg::ERR_OUT_W-1:0] error_now
);
  import ips_pkg::*;

  localparam int EW   = DATA_WIDTH + 1;
  localparam int XW   = ((EW > ERR_STATE_W) ? EW : ERR_STATE_W) + 3;
  localparam int KW   = 2 * CFG_W;
  localparam int NUMW = KW + 1 + XW;
  localparam int PW   = CFG_W + 1 + XW;
  localparam int IW   = KW + 1 + EW;
  localparam int SW   = NUMW + 2;

  logic signed [EW-1:0]          e_r;
  logic signed [ERR_STATE_W-1:0] err_prev_r;
  logic signed [ERR_STATE_W-1:0] err_prev2_r;
  logic [KW-1:0]                 kpts_r;
  logic [KW-1:0]                 kptd_r;
  logic signed [XW-1:0]          d1_r;
  logic signed [XW-1:0]          d2_r;
  logic signed [NUMW-1:0]        ni_r;
  logic signed [NUMW-1:0]        nd_r;
  logic signed [PW-1:0]          p_r;
  logic signed [NUMW-1:0]        i_r;
  logic signed [NUMW-1:0]        d_r;
  logic signed [SW-1:0]          sum_r;
  logic                          out_valid_r;
  logic signed [INC_W-1:0]       out_inc_r;
  logic signed [ERR_OUT_W-1:0]   out_err_r;

  logic signed [EW-1:0]          e_nxt;
  logic signed [XW-1:0]          ex;
  logic signed [XW-1:0]          e1x;
  logic signed [XW-1:0]          e2x;
  logic signed [IW-1:0]          ni_prod;
  logic signed [NUMW-1:0]        nd_prod;
  logic signed [PW-1:0]          p_prod;
  logic signed [SW-1:0]          shifted;
  logic [SW-INC_W:0]             hi;
  logic signed [INC_W-1:0]       inc_sat;

  logic                          div_start;
  logic signed [NUMW-1:0]        div_num;
  logic [CFG_W-1:0]              div_den;
  logic                          div_done;
  logic signed [NUMW-1:0]        div_quot;

  assign e_nxt   = EW'(setpoint) - EW'(measurement);
  assign ex      = XW'(e_r);
  assign e1x     = XW'(err_prev_r);
  assign e2x     = XW'(err_prev2_r);
  assign ni_prod = $signed({1'b0, kpts_r}) * e_r;
  assign nd_prod = $signed({1'b0, kptd_r}) * d2_r;
  assign p_prod  = $signed({1'b0, cfg.kp}) * d1_r;

  assign shifted = sum_r >>> GAIN_FRAC_BITS;
  assign hi      = shifted[SW-1:INC_W-1];

  always_comb begin
    if (hi == '0 || hi == '1) begin
      inc_sat = shifted[INC_W-1:0];
    end else if (shifted[SW-1]) begin
      inc_sat = INC_MIN;
    end else begin
      inc_sat = INC_MAX;
    end
  end

  assign div_start = cmd.div_i_start || cmd.div_d_start;
  assign div_num   = cmd.div_i_start ? ni_r : nd_r;
  assign div_den   = cmd.div_i_start ? cfg.ti : cfg.ts;

  ips_div #(
    .NUM_W (NUMW),
    .DEN_W (CFG_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_prev_r  <= '0;
      err_prev2_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.diff) begin
        err_prev2_r <= err_prev_r;
        err_prev_r  <= ex[ERR_STATE_W-1:0];
      end
      if (cmd.fin) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      e_r    <= e_nxt;
      kpts_r <= cfg.kp * cfg.ts;
      kptd_r <= cfg.kp * cfg.td;
    end
    if (cmd.diff) begin
      d1_r <= ex - e1x;
      d2_r <= ex - (e1x <<< 1) + e2x;
      ni_r <= NUMW'(ni_prod);
    end
    if (cmd.mul) begin
      p_r  <= p_prod;
      nd_r <= nd_prod;
    end
    if (cmd.i_take) begin
      i_r <= div_quot;
    end else if (cmd.i_clear) begin
      i_r <= '0;
    end
    if (cmd.d_take) begin
      d_r <= div_quot;
    end else if (cmd.d_clear) begin
      d_r <= '0;
    end
    if (cmd.sum) begin
      sum_r <= SW'(p_r) + SW'(i_r) + SW'(d_r);
    end
    if (cmd.fin) begin
      out_inc_r <= inc_sat;
      out_err_r <= ex[ERR_OUT_W-1:0];
    end
  end

  assign sts.i_off    = (cfg.ti == '0);
  assign sts.d_off    = (cfg.td == '0) || (cfg.ts == '0);
  assign sts.div_done = div_done;
  assign sts.out_busy = out_valid_r && !out_ready;

  assign out_valid = out_valid_r;
  assign increment = out_inc_r;
  assign error_now = out_err_r;

endmodule

### src/ips_ctrl.sv
// Sequencer: steps one word through difference, products, up to two divides, sum, output.
// Depends on ips_pkg; drives ips_dp through the command struct.
module ips_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ips_pkg::ips_sts_t  sts,
  output ips_pkg::ips_cmd_t  cmd
);
  import ips_pkg::*;

  ips_state_t state_r;
  ips_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_DIV_I;
      end
      ST_DIV_I: begin
        if (sts.i_off) begin
          cmd.i_clear = 1'b1;
          state_nxt   = ST_DIV_D;
        end else begin
          cmd.div_i_start = 1'b1;
          state_nxt       = ST_WAIT_I;
        end
      end
      ST_WAIT_I: begin
        if (sts.div_done) begin
          cmd.i_take = 1'b1;
          state_nxt  = ST_DIV_D;
        end
      end
      ST_DIV_D: begin
        if (sts.d_off) begin
          cmd.d_clear = 1'b1;
          state_nxt   = ST_SUM;
        end else begin
          cmd.div_d_start = 1'b1;
          state_nxt       = ST_WAIT_D;
        end
      end
      ST_WAIT_D: begin
        if (sts.div_done) begin
          cmd.d_take = 1'b1;
          state_nxt  = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!sts.out_busy) begin
          cmd.fin   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### tb/incremental_pid_step_unit_test.sv
// Self-checking testbench for incremental_pid_step_unit: APB register setup,
// random sample streams with bursty sender and stalling receiver, scoreboard check.
// Depends on ips_pkg, ips_if and the incremental_pid_step_unit RTL.
module incremental_pid_step_unit_test;
  import ips_pkg::*;

  localparam int DATA_W          = DEF_DATA_WIDTH;
  localparam int FRAC_W          = DEF_GAIN_FRAC_BITS;
  localparam int IDLE_LIMIT      = 4000;
  localparam int RANDOM_PHASES   = 10;
  localparam int ITEMS_PER_PHASE = 168;
  localparam int DRAIN_CYCLES    = 80;

  typedef struct packed {
    logic signed [INC_W-1:0]     increment;
    logic signed [ERR_OUT_W-1:0] error_now;
  } pid_result_t;

  class increment_tracker;
    logic [CFG_W-1:0] kp, ti, td, ts;
    longint           err_prev, err_prev2;
    pid_result_t      incr_q[$];
    int               mismatches, checked, noted;

    function new();
      kp = '0;
      ti = '0;
      td = '0;
      ts = TS_RESET;
      err_prev = 0;
      err_prev2 = 0;
      mismatches = 0;
      checked = 0;
      noted = 0;
    endfunction

    function void set_reg(ips_reg_t idx, logic [CFG_W-1:0] value);
      case (idx)
        REG_KP: kp = value;
        REG_TI: ti = value;
        REG_TD: td = value;
        REG_TS: ts = value;
        default: ;
      endcase
    endfunction

    function int pending();
      return incr_q.size();
    endfunction

    function void note_sample(logic signed [DATA_W-1:0] sp, logic signed [DATA_W-1:0] ms);
      longint                        err, d1, d2, p_t, i_t, d_t, total;
      logic signed [ERR_STATE_W-1:0] err_st;
      pid_result_t                   res;
      err = longint'(sp) - longint'(ms);
      d1 = err - err_prev;
      d2 = err - 2 * err_prev + err_prev2;
      p_t = longint'(kp) * d1;
      i_t = 0;
      d_t = 0;
      if (ti != 0) i_t = (longint'(kp) * longint'(ts) * err) / longint'(ti);
      if (td != 0 && ts != 0) d_t = (longint'(td) * longint'(kp) * d2) / longint'(ts);
      total = (p_t + i_t + d_t) >>> FRAC_W;
      if (total > longint'(INC_MAX)) total = longint'(INC_MAX);
      if (total < longint'(INC_MIN)) total = longint'(INC_MIN);
      res.increment = total[INC_W-1:0];
      res.error_now = err[ERR_OUT_W-1:0];
      incr_q.push_back(res);
      noted++;
      err_st = err[ERR_STATE_W-1:0];
      err_prev2 = err_prev;
      err_prev = err_st;
    endfunction

    task report(string what, longint got, longint want);
      $display("MISMATCH %s: got %0d, want %0d (after %0d samples)", what, got, want, noted);
      mismatches++;
    endtask

    task check_result(logic signed [INC_W-1:0] incr, logic signed [ERR_OUT_W-1:0] err);
      pid_result_t want;
      if (incr_q.size() == 0) begin
        report("increment with no sample pending", incr, 0);
      end else begin
        want = incr_q.pop_front();
        checked++;
        if (incr !== want.increment) report("increment", incr, $signed(want.increment));
        if (err !== want.error_now) report("error_now", err, $signed(want.error_now));
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  psel, penable, pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  increment_tracker         tracker;
  int                       burst_left;
  int                       settings_count;
  int                       idle_cycles;
  logic                     in_fire, out_fire, cfg_fire;
  logic signed [DATA_W-1:0] last_sp, last_ms;
  logic signed [DATA_W-1:0] rnd_sp, rnd_ms;

  always #5 clk = ~clk;

  ips_in_if #(.DATA_WIDTH(DATA_W)) in_ch();
  ips_out_if out_ch();

  incremental_pid_step_unit #(
    .GAIN_FRAC_BITS(FRAC_W),
    .DATA_WIDTH    (DATA_W)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  task send_sample(input logic signed [DATA_W-1:0] sp, input logic signed [DATA_W-1:0] ms);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      case ($urandom_range(0, 3))
        0: gap = 0;
        1: gap = $urandom_range(1, 4);
        2: gap = $urandom_range(5, 40);
        default: gap = $urandom_range(41, 90);
      endcase
      if (gap > 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid = 1'b1;
    in_ch.setpoint = sp;
    in_ch.measurement = ms;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task write_reg(input ips_reg_t idx, input logic [CFG_W-1:0] value);
    logic [APB_DATA_W-1:0] rd;
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = {16'($urandom), value};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    tracker.set_reg(idx, value);
    @(negedge clk);
    pwrite = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    if (rd[CFG_W-1:0] !== value) tracker.report("register readback", rd[CFG_W-1:0], value);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task wait_drained();
    while (tracker.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task set_config(input logic [CFG_W-1:0] kp, input logic [CFG_W-1:0] ti,
                  input logic [CFG_W-1:0] td, input logic [CFG_W-1:0] ts);
    in_ch.valid = 1'b0;
    wait_drained();
    write_reg(REG_KP, kp);
    write_reg(REG_TI, ti);
    write_reg(REG_TD, td);
    write_reg(REG_TS, ts);
    settings_count++;
  endtask

  function logic [CFG_W-1:0] pick_setting(bit no_zero);
    logic [CFG_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = no_zero ? CFG_W'(1) : CFG_W'(0);
      1: v = '1;
      2, 3, 4: v = CFG_W'($urandom_range(1, 512));
      default: v = CFG_W'($urandom_range(no_zero ? 1 : 0, 65535));
    endcase
    return v;
  endfunction

  task pick_sample(output logic signed [DATA_W-1:0] sp, output logic signed [DATA_W-1:0] ms);
    int base, near;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        sp = DATA_W'($urandom);
        ms = DATA_W'($urandom);
      end
      5, 6, 7: begin
        base = $urandom_range(0, 65535) - 32768;
        near = base + $urandom_range(0, 64) - 32;
        if (near > 32767) near = 32767;
        if (near < -32768) near = -32768;
        sp = base[DATA_W-1:0];
        ms = near[DATA_W-1:0];
      end
      8: begin
        sp = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        ms = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      end
      default: begin
        sp = last_sp;
        ms = last_ms;
      end
    endcase
    last_sp = sp;
    last_ms = ms;
  endtask

  initial begin : rx_stall
    int mode, left;
    out_ch.ready = 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = (mode == 2) ? $urandom_range(1, 150) : $urandom_range(1, 200);
      end
      left--;
      case (mode)
        0: out_ch.ready = 1'b1;
        1: out_ch.ready = $urandom_range(0, 1);
        2: out_ch.ready = 1'b0;
        default: out_ch.ready = ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      in_fire = in_ch.valid && in_ch.ready;
      out_fire = out_ch.valid && out_ch.ready;
      cfg_fire = psel && penable && pready;
      if (in_fire) tracker.note_sample(in_ch.setpoint, in_ch.measurement);
      if (out_fire) tracker.check_result(out_ch.increment, out_ch.error_now);
      if (in_fire || out_fire || cfg_fire) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("no word accepted for %0d cycles", IDLE_LIMIT);
        $display("incremental_pid_step_unit verification failed");
        $finish;
      end
    end
  end

  initial begin
    tracker = new();
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.setpoint = '0;
    in_ch.measurement = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    burst_left = 0;
    settings_count = 1;
    idle_cycles = 0;
    last_sp = '0;
    last_ms = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // reset settings: zero gain
    send_sample(16'sh7fff, 16'sh8000);
    send_sample(16'sh8000, 16'sh7fff);

    // full gain and derivative: drive saturation both ways
    set_config(16'hffff, 16'd1, 16'hffff, 16'd1);
    send_sample(16'sh7fff, 16'sh8000);
    send_sample(16'sh8000, 16'sh7fff);
    send_sample(16'sh7fff, 16'sh8000);
    send_sample(16'sh0000, 16'sh0000);
    send_sample(16'sh8000, 16'sh8000);

    // integral and derivative off, floor of small negatives
    set_config(16'd1, 16'd0, 16'd0, 16'hffff);
    send_sample(16'sh0000, 16'sh0001);
    send_sample(16'sh0000, 16'sh0001);
    send_sample(16'sh0001, 16'sh0000);
    send_sample(16'sh0000, 16'sh0000);
    send_sample(-16'sd5, 16'sd3);

    // truncation of both quotients on negative numerators
    set_config(16'd3, 16'd7, 16'd5, 16'd3);
    send_sample(-16'sd100, 16'sd23);
    send_sample(16'sd17, -16'sd4);
    send_sample(-16'sd1, 16'sd0);
    send_sample(16'sd200, 16'sd201);
    send_sample(16'sh7fff, 16'sh0000);

    set_config(16'd256, 16'hffff, 16'd1, 16'hffff);
    send_sample(16'sd1000, 16'sd0);
    send_sample(-16'sd1000, 16'sd0);
    send_sample(16'sd12345, -16'sd12345);
    send_sample(16'sd0, 16'sd0);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      set_config(pick_setting(1'b0), pick_setting(1'b0), pick_setting(1'b0),
                 pick_setting(1'b1));
      repeat (ITEMS_PER_PHASE) begin
        pick_sample(rnd_sp, rnd_ms);
        send_sample(rnd_sp, rnd_ms);
      end
    end

    in_ch.valid = 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.pending() != 0)
      tracker.report("samples left without increment", tracker.pending(), 0);

    $display("covered %0d samples under %0d register settings, %0d increments compared",
             tracker.noted, settings_count, tracker.checked);
    $display("mismatches: %0d", tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("incremental_pid_step_unit verification clean");
    end else begin
      $display("incremental_pid_step_unit verification failed");
    end
    $finish;
  end

endmodule

### incremental_pid_step_unit.f
src/ips_pkg.sv
src/ips_if.sv
src/ips_regs.sv
src/ips_div.sv
src/ips_dp.sv
src/ips_ctrl.sv
src/incremental_pid_step_unit.sv
tb/incremental_pid_step_unit_test.sv
